@@ rtl/twmf_pkg.sv @@
// Shared types and constants of the trimmed window median filter.
package twmf_pkg;

  localparam int unsigned RawW     = 8;
  localparam int unsigned SampleW  = 9;
  localparam int unsigned WinRegW  = 5;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;

  localparam logic [WinRegW-1:0] WinSizeReset = 5'd5;
  localparam int unsigned        WinMin       = 3;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegWindowSize = 1'd0;
  localparam logic [CfgIdxW-1:0] RegSignedMode = 1'd1;

  // Input function codes
  localparam logic FuncSample = 1'b0;
  localparam logic FuncClear  = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StWrite,
    StRead,
    StWait,
    StPick,
    StOut
  } state_e;

  // Control from the sequencer to the rank unit
  typedef struct packed {
    logic load;    // read data of the lane index is valid this cycle
    logic sel_en;  // register the selected element
  } rank_ctrl_t;

endpackage

@@ rtl/twmf_if.sv @@
// Valid/ready channel interfaces for sample beats and result beats.
interface twmf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [twmf_pkg::RawW-1:0] raw_value;

  modport source (output valid, output func, output raw_value, input ready);
  modport sink   (input valid, input func, input raw_value, output ready);
endinterface

interface twmf_out_if;
  logic                      valid;
  logic                      ready;
  logic [twmf_pkg::RawW-1:0] median_value;

  modport source (output valid, output median_value, input ready);
  modport sink   (input valid, input median_value, output ready);
endinterface

@@ rtl/twmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module twmf_ram #(
  parameter int unsigned Width = 9,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/twmf_rank.sv @@
// Incremental rank unit: lanes take the window one beat a cycle, then pick a rank.
module twmf_rank #(
  parameter int unsigned MaxWindow = 16
) (
  input  logic                                    clk_i,
  input  twmf_pkg::rank_ctrl_t                    ctrl_i,
  input  logic [$clog2(MaxWindow)-1:0]            lane_i,
  input  logic signed [twmf_pkg::SampleW-1:0]     data_i,
  input  logic [$clog2(MaxWindow+1)-1:0]          win_i,
  input  logic [$clog2(MaxWindow)-1:0]            rank_sel_i,
  output logic [twmf_pkg::RawW-1:0]               pick_o
);

  localparam int unsigned LW = $clog2(MaxWindow);
  localparam int unsigned CW = $clog2(MaxWindow + 1);

  logic signed [twmf_pkg::SampleW-1:0] val_q  [MaxWindow];
  logic        [LW-1:0]                rank_q [MaxWindow];
  logic [MaxWindow-1:0]                older_le;  // earlier lane <= new value
  logic [LW-1:0]                       new_rank;
  logic [twmf_pkg::SampleW-1:0]        pick_d;
  logic [twmf_pkg::RawW-1:0]           pick_q;

  always_comb begin
    new_rank = '0;
    for (int i = 0; i < MaxWindow; i++) begin
      older_le[i] = (LW'(i) < lane_i) && (val_q[i] <= data_i);
      new_rank    = new_rank + LW'(older_le[i]);
    end
  end

  // Each earlier lane holding a larger value moves up one place; ties keep arrival order.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int i = 0; i < MaxWindow; i++) begin
        if (LW'(i) == lane_i) begin
          val_q[i]  <= data_i;
          rank_q[i] <= new_rank;
        end else if (LW'(i) < lane_i && !older_le[i]) begin
          rank_q[i] <= rank_q[i] + LW'(1);
        end
      end
    end
  end

  always_comb begin
    pick_d = '0;
    for (int i = 0; i < MaxWindow; i++) begin
      if (CW'(i) < win_i && rank_q[i] == rank_sel_i) begin
        pick_d = pick_d | val_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sel_en) begin
      pick_q <= pick_d[twmf_pkg::RawW-1:0];
    end
  end

  assign pick_o = pick_q;

endmodule

@@ rtl/trimmed_window_median_filter_top.sv @@
// Top level of the trimmed window median filter: sequencer, ring pointers, output register.
//
// Usage: in_bus carries one beat per sensor event: func selects a new sample
//   or a clear of the window; raw_value is the sensor byte (ignored on a clear).
//   out_bus carries one median_value beat per sample once the window is full.
//   The configuration port writes the window length (index 0, clamped to
//   3..MaxWindow) and signed_mode (index 1); write only while the block is idle.
// Steps: a clear beat is absorbed in the cycle it is accepted. A sample beat
//   that gives no result is accepted and written into the ring; one that
//   does (W the effective window) is accepted, written into the ring, then
//   takes W reads through the single read port of the sample RAM, read latency,
//   rank selection and output register load. No new beat is accepted until
//   the sample beat is through; the RAM read port sets its length.
// Reset: the window is empty, the length is 5 and signed_mode is 0. The
//   sample RAM is not cleared; only written entries are read back.
// Stall: a result waits in the output register while the receiver holds ready
//   low; the next sample is accepted and worked on meanwhile, and its result
//   waits in the rank unit until the output register is free.
module trimmed_window_median_filter_top #(
  parameter int unsigned MaxWindow = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  twmf_in_if.sink                         in_bus,
  twmf_out_if.source                      out_bus,
  input  logic                            cfg_we_i,
  input  logic [twmf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [twmf_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned LW  = $clog2(MaxWindow);      // ring slot / lane index
  localparam int unsigned CW  = $clog2(MaxWindow + 1);  // fill count, window
  localparam int unsigned SW  = CW + 1;                 // ring sums before wrap
  localparam int unsigned WsW = (CW > twmf_pkg::WinRegW) ? CW : twmf_pkg::WinRegW;

  // Configuration registers
  logic [twmf_pkg::WinRegW-1:0] win_len_q;
  logic                         signed_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q     <= twmf_pkg::WinSizeReset;
      signed_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        twmf_pkg::RegWindowSize: win_len_q <= cfg_data_i[twmf_pkg::WinRegW-1:0];
        twmf_pkg::RegSignedMode: signed_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective window, clamped to the supported range
  logic [WsW-1:0] ws_ext;
  logic [CW-1:0]  win;
  logic [LW-1:0]  rank_sel;

  always_comb begin
    ws_ext = WsW'(win_len_q);
    if (ws_ext < WsW'(twmf_pkg::WinMin)) begin
      win = CW'(twmf_pkg::WinMin);
    end else if (ws_ext > WsW'(MaxWindow)) begin
      win = CW'(MaxWindow);
    end else begin
      win = CW'(ws_ext);
    end
  end

  // Without the extremes, rank 1 + (W-2)/2 of the sorted window is W/2.
  assign rank_sel = LW'(win >> 1);

  // Sequencer and ring state
  twmf_pkg::state_e state_q, state_d;
  logic [CW-1:0]                 fill_q, fill_d;
  logic [LW-1:0]                 oldest_q, oldest_d;
  logic [LW-1:0]                 rd_cnt_q, rd_cnt_d;
  logic [twmf_pkg::SampleW-1:0]  sample_q;
  logic                          rd_v_q;
  logic [LW-1:0]                 rd_lane_q;

  logic          in_fire;
  logic          out_free;
  logic [SW-1:0] total;
  logic [SW-1:0] pos_sum;
  logic [LW-1:0] wr_pos;
  logic [SW-1:0] shift_sum;
  logic [SW-1:0] rd_sum;
  logic [LW-1:0] rd_addr;
  logic          last_rd;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_free = !out_bus.valid || out_bus.ready;

  always_comb begin
    total     = SW'(fill_q) + SW'(1);
    pos_sum   = SW'(oldest_q) + SW'(fill_q);
    wr_pos    = (pos_sum >= SW'(MaxWindow)) ? LW'(pos_sum - SW'(MaxWindow)) : LW'(pos_sum);
    // oldest moves on by however many samples exceed the window
    shift_sum = SW'(oldest_q) + (total - SW'(win));
    rd_sum    = SW'(oldest_q) + SW'(rd_cnt_q);
    rd_addr   = (rd_sum >= SW'(MaxWindow)) ? LW'(rd_sum - SW'(MaxWindow)) : LW'(rd_sum);
    last_rd   = (CW'(rd_cnt_q) == win - CW'(1));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      twmf_pkg::StIdle: begin
        if (in_fire && in_bus.func == twmf_pkg::FuncSample) state_d = twmf_pkg::StWrite;
      end
      twmf_pkg::StWrite: begin
        state_d = (total >= SW'(win)) ? twmf_pkg::StRead : twmf_pkg::StIdle;
      end
      twmf_pkg::StRead: begin
        if (last_rd) state_d = twmf_pkg::StWait;
      end
      twmf_pkg::StWait: state_d = twmf_pkg::StPick;
      twmf_pkg::StPick: state_d = twmf_pkg::StOut;
      twmf_pkg::StOut: begin
        if (out_free) state_d = twmf_pkg::StIdle;
      end
      default: state_d = twmf_pkg::StIdle;
    endcase
  end

  // Ring pointers and read counter
  always_comb begin
    fill_d   = fill_q;
    oldest_d = oldest_q;
    rd_cnt_d = rd_cnt_q;
    case (state_q)
      twmf_pkg::StIdle: begin
        rd_cnt_d = '0;
        if (in_fire && in_bus.func == twmf_pkg::FuncClear) begin
          fill_d   = '0;
          oldest_d = '0;
        end
      end
      twmf_pkg::StWrite: begin
        if (total > SW'(win)) begin
          fill_d   = win;
          oldest_d = (shift_sum >= SW'(MaxWindow)) ? LW'(shift_sum - SW'(MaxWindow))
                                                   : LW'(shift_sum);
        end else begin
          fill_d = CW'(total);
        end
      end
      twmf_pkg::StRead: rd_cnt_d = rd_cnt_q + LW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= twmf_pkg::StIdle;
      fill_q    <= '0;
      oldest_q  <= '0;
      rd_cnt_q  <= '0;
      rd_v_q    <= 1'b0;
      rd_lane_q <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      oldest_q  <= oldest_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_v_q    <= (state_q == twmf_pkg::StRead);
      rd_lane_q <= rd_cnt_q;
    end
  end

  // Sample in its stored form: sign-extended in signed mode
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= {signed_mode_q & in_bus.raw_value[twmf_pkg::RawW-1], in_bus.raw_value};
    end
  end

  // Sample RAM holding the ring
  logic                         ram_we;
  logic                         ram_re;
  logic [twmf_pkg::SampleW-1:0] ram_rdata;

  always_comb begin
    ram_we = (state_q == twmf_pkg::StWrite);
    ram_re = (state_q == twmf_pkg::StRead);
  end

  twmf_ram #(
    .Width (twmf_pkg::SampleW),
    .Depth (MaxWindow)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_pos),
    .wdata_i (sample_q),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Rank unit
  twmf_pkg::rank_ctrl_t      rank_ctrl;
  logic [twmf_pkg::RawW-1:0] pick;

  always_comb begin
    rank_ctrl.load   = rd_v_q;
    rank_ctrl.sel_en = (state_q == twmf_pkg::StPick);
  end

  twmf_rank #(
    .MaxWindow (MaxWindow)
  ) u_rank (
    .clk_i      (clk_i),
    .ctrl_i     (rank_ctrl),
    .lane_i     (rd_lane_q),
    .data_i     (ram_rdata),
    .win_i      (win),
    .rank_sel_i (rank_sel),
    .pick_o     (pick)
  );

  // Output register: a negative pick keeps its low byte, which is the raw form
  logic                      out_valid_q, out_valid_d;
  logic [twmf_pkg::RawW-1:0] median_q;
  logic                      out_load;

  always_comb begin
    out_load    = (state_q == twmf_pkg::StOut) && out_free;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      median_q <= pick;
    end
  end

  assign in_bus.ready         = (state_q == twmf_pkg::StIdle);
  assign out_bus.valid        = out_valid_q;
  assign out_bus.median_value = median_q;

endmodule

@@ sim/tb.sv @@
// Testbench for the trimmed window median filter: table-driven directed beats, then random phases.
module tb;

  localparam int unsigned MaxWin    = 16;
  // Long enough to cover a sample beat still in work at W = 16.
  localparam int unsigned Settle    = 24;
  localparam int unsigned Phases    = 16;
  localparam int unsigned PhaseLen  = 116;
  localparam int unsigned PendDepth = 64;

  typedef enum logic {RowBeat, RowCfg} row_kind_e;
  // How a directed row is checked: by the predictor, by a value typed into the table, or as giving no median
  typedef enum logic [1:0] {ByModel, NoMedian, Median} row_chk_e;

  typedef struct packed {
    row_kind_e                     kind;
    row_chk_e                      chk;
    logic                          func;
    logic [twmf_pkg::RawW-1:0]     raw;
    logic [twmf_pkg::CfgIdxW-1:0]  idx;
    logic [twmf_pkg::CfgDataW-1:0] val;
    logic [twmf_pkg::RawW-1:0]     median;
  } dir_row_t;

  // Directed rows. Starts from the reset setting: W = 5, unsigned.
  localparam dir_row_t DirRows [17] = '{
    '{RowBeat, NoMedian, twmf_pkg::FuncSample, 8'd0,   twmf_pkg::RegWindowSize, 5'd0, 8'd0},
    '{RowBeat, NoMedian, twmf_pkg::FuncSample, 8'd255, twmf_pkg::RegWindowSize, 5'd0, 8'd0},
    '{RowBeat, NoMedian, twmf_pkg::FuncSample, 8'd128, twmf_pkg::RegWindowSize, 5'd0, 8'd0},
    '{RowBeat, NoMedian, twmf_pkg::FuncSample, 8'd127, twmf_pkg::RegWindowSize, 5'd0, 8'd0},
    // window now full: {0,255,128,127,1}
    '{RowBeat, Median,   twmf_pkg::FuncSample, 8'd1,   twmf_pkg::RegWindowSize, 5'd0, 8'd127},
    '{RowBeat, Median,   twmf_pkg::FuncSample, 8'd255, twmf_pkg::RegWindowSize, 5'd0, 8'd128},
    // window below three acts as three; also shrinks a full window
    '{RowCfg,  ByModel,  twmf_pkg::FuncSample, 8'd0,   twmf_pkg::RegWindowSize, 5'd0, 8'd0},
    '{RowBeat, Median,   twmf_pkg::FuncSample, 8'd2,   twmf_pkg::RegWindowSize, 5'd0, 8'd2},
    // mode change while full: the held 255 stays positive
    '{RowCfg,  ByModel,  twmf_pkg::FuncSample, 8'd0,   twmf_pkg::RegSignedMode, 5'd1, 8'd0},
    '{RowBeat, Median,   twmf_pkg::FuncSample, 8'h80,  twmf_pkg::RegWindowSize, 5'd0, 8'd2},
    '{RowBeat, Median,   twmf_pkg::FuncSample, 8'hff,  twmf_pkg::RegWindowSize, 5'd0, 8'hff},
    // window grown while full: two silent beats, then an even-W median
    '{RowCfg,  ByModel,  twmf_pkg::FuncSample, 8'd0,   twmf_pkg::RegWindowSize, 5'd6, 8'd0},
    '{RowBeat, NoMedian, twmf_pkg::FuncSample, 8'h7f,  twmf_pkg::RegWindowSize, 5'd0, 8'd0},
    '{RowBeat, NoMedian, twmf_pkg::FuncSample, 8'h01,  twmf_pkg::RegWindowSize, 5'd0, 8'd0},
    '{RowBeat, ByModel,  twmf_pkg::FuncSample, 8'h81,  twmf_pkg::RegWindowSize, 5'd0, 8'd0},
    // clear ignores its byte and gives nothing; the refill starts from empty
    '{RowBeat, NoMedian, twmf_pkg::FuncClear,  8'haa,  twmf_pkg::RegWindowSize, 5'd0, 8'd0},
    '{RowBeat, NoMedian, twmf_pkg::FuncSample, 8'h55,  twmf_pkg::RegWindowSize, 5'd0, 8'd0}
  };

  // Window settings per random phase: clamped low and high ends, odd and even sizes
  localparam logic [twmf_pkg::CfgDataW-1:0] PhaseWin [Phases] = '{
    5'd3, 5'd16, 5'd0, 5'd31, 5'd4, 5'd1, 5'd17, 5'd2,
    5'd8, 5'd15, 5'd5, 5'd6, 5'd9, 5'd11, 5'd7, 5'd16
  };
  localparam logic [twmf_pkg::RawW-1:0] EdgeRaw [4] = '{8'd0, 8'd127, 8'd128, 8'd255};

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [twmf_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [twmf_pkg::CfgDataW-1:0] cfg_data_i;

  twmf_in_if  in_bus ();
  twmf_out_if out_bus ();

  trimmed_window_median_filter_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Idle and stall rates, in percent per cycle, set per phase
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned err_count     = 0;

  // Medians predicted but not yet seen on out_bus, oldest first, as a ring
  logic [twmf_pkg::RawW-1:0] pend_buf [PendDepth];
  int unsigned               pend_wr = 0;
  int unsigned               pend_rd = 0;

  // Predictor state: the sample ring, its fill and oldest slot, and a copy of the registers
  logic signed [twmf_pkg::SampleW-1:0] held_samples [MaxWin];
  int unsigned                         held_n;
  int unsigned                         head_slot;
  logic [twmf_pkg::WinRegW-1:0]        win_reg;
  logic                                sign_reg;

  function automatic void note_median(input logic [twmf_pkg::RawW-1:0] m);
    pend_buf[pend_wr % PendDepth] = m;
    pend_wr++;
  endfunction

  // Takes one beat into the predicted window; returns 1 and the median when one is due.
  function automatic bit filter_beat(input logic f, input logic [twmf_pkg::RawW-1:0] raw,
                                     output logic [twmf_pkg::RawW-1:0] med);
    int unsigned                         w, n, i, j;
    logic signed [twmf_pkg::SampleW-1:0] s, v;
    logic signed [twmf_pkg::SampleW-1:0] ord [MaxWin];
    w   = (win_reg < twmf_pkg::WinMin) ? twmf_pkg::WinMin :
          (win_reg > MaxWin) ? MaxWin : int'(win_reg);
    med = '0;
    if (f == twmf_pkg::FuncClear) begin
      held_n    = 0;
      head_slot = 0;
      return 1'b0;
    end
    s = (sign_reg && raw[7]) ? {1'b1, raw} : {1'b0, raw};
    held_samples[(head_slot + held_n) % MaxWin] = s;
    n = held_n + 1;
    // drop as many of the oldest as needed to leave W held (shrunk window included)
    if (n > w) begin
      head_slot = (head_slot + n - w) % MaxWin;
      n = w;
    end
    held_n = n;
    if (held_n < w) return 1'b0;
    for (i = 0; i < w; i++) begin
      v = held_samples[(head_slot + i) % MaxWin];
      j = i;
      while (j > 0 && ord[j-1] > v) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = v;
    end
    // skip the minimum, then index (W-2)/2 of what is left; low byte is the raw form
    v   = ord[1 + (w - 2) / 2];
    med = v[twmf_pkg::RawW-1:0];
    return 1'b1;
  endfunction

  // One input beat, after a random idle run; valid stays high on return so that
  // back-to-back beats never lower and raise it in the same step.
  task automatic send_beat(input logic f, input logic [twmf_pkg::RawW-1:0] v,
                           input row_chk_e chk, input logic [twmf_pkg::RawW-1:0] typed);
    logic [twmf_pkg::RawW-1:0] med;
    bit                        got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.func      <= f;
    in_bus.raw_value <= v;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    got = filter_beat(f, v, med);
    if (chk == ByModel) begin
      if (got) note_median(med);
    end else if (chk == Median) begin
      note_median(typed);
    end
  endtask

  // Holds the sender off until every predicted median has come, then lets the settle
  // time pass for a silent beat that may still be in work. settle must be >= 1.
  task automatic wait_drained(input int unsigned settle);
    in_bus.valid <= 1'b0;
    while (pend_wr != pend_rd) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Register write that lowers the enable again before it returns, so back-to-back writes never
  // drop and raise the enable in one step.
  task automatic write_reg(input logic [twmf_pkg::CfgIdxW-1:0] idx,
                           input logic [twmf_pkg::CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == twmf_pkg::RegWindowSize) win_reg = val;
    else sign_reg = val[0];
    @(posedge clk_i);
  endtask

  // Result side: random ready, every accepted beat checked against the oldest prediction
  initial begin : result_check
    logic [twmf_pkg::RawW-1:0] want;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        if (pend_wr == pend_rd) begin
          err_count++;
          $error("median_value: expected none, got %0d", out_bus.median_value);
        end else begin
          want = pend_buf[pend_rd % PendDepth];
          pend_rd++;
          if (want !== out_bus.median_value) begin
            err_count++;
            $error("median_value: expected %0d, got %0d", want, out_bus.median_value);
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : stimulus
    logic [twmf_pkg::RawW-1:0] v;
    logic                      f;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= twmf_pkg::RegWindowSize;
    cfg_data_i       <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.func      <= twmf_pkg::FuncSample;
    in_bus.raw_value <= '0;
    held_n    = 0;
    head_slot = 0;
    win_reg   = twmf_pkg::WinSizeReset;
    sign_reg  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling
    foreach (DirRows[r]) begin
      if (DirRows[r].kind == RowCfg) begin
        wait_drained(Settle);
        write_reg(DirRows[r].idx, DirRows[r].val);
      end else begin
        send_beat(DirRows[r].func, DirRows[r].raw, DirRows[r].chk, DirRows[r].median);
      end
    end

    // Random phases. The window is not cleared between phases, so each new
    // setting lands on a full or part-full window: shrink, grow and mode change.
    for (int p = 0; p < Phases; p++) begin
      wait_drained(Settle);
      write_reg(twmf_pkg::RegWindowSize, PhaseWin[p]);
      write_reg(twmf_pkg::RegSignedMode, twmf_pkg::CfgDataW'(p[2]));
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      repeat (PhaseLen) begin
        // mostly samples; the odd clear breaks a fill part-way
        f = ($urandom_range(99) < 3) ? twmf_pkg::FuncClear : twmf_pkg::FuncSample;
        case ($urandom_range(9))
          6:       v = EdgeRaw[$urandom_range(3)];
          // tight cluster round the sign boundary gives ties and mixed signs
          7, 8, 9: v = twmf_pkg::RawW'($urandom_range(129, 126));
          default: v = twmf_pkg::RawW'($urandom());
        endcase
        // now and then the sender waits for the pipeline to empty
        if ($urandom_range(199) == 0) wait_drained(1);
        send_beat(f, v, ByModel, '0);
      end
    end

    wait_drained(Settle);
    if (err_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  // Watchdog: roughly ten times the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
